[src/delta_list_timer_queue_defines.svh]
// Assertion macros shared by the checker.
`ifndef DELTA_LIST_TIMER_QUEUE_DEFINES_SVH
`define DELTA_LIST_TIMER_QUEUE_DEFINES_SVH

`define DLTQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define DLTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/dltq_pkg.sv]
package dltq_pkg;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int DELAY_WIDTH_DEF = 24;
   localparam int ID_WIDTH_DEF    = 16;
   localparam int MAX_RESULTS     = 16;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_SLEEP  = 2'd1,
      OP_SCHED  = 2'd2,
      OP_CANCEL = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NO_IDS    = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_CMP,
      S_INS_LINK,
      S_INS_PATCH,
      S_CAN_CMP,
      S_TICK_CMP,
      S_TICK_REST,
      S_TICK_END,
      S_OUT
   } state_type;

   typedef struct packed {
      logic       event_valid;
      logic       event_kind;
      logic [15:0] event_handle;
      logic [15:0] assigned_id;
      logic       resched;
      status_type status;
      logic       last;
   } rsp_type;
endpackage

[src/dltq_if.sv]
interface dltq_req_if;
   import dltq_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [23:0] delay_ticks;
   logic [7:0]  elapsed_ticks;
   logic [15:0] handle;
   modport source (output valid, opcode, delay_ticks, elapsed_ticks, handle, input ready);
   modport sink (input valid, opcode, delay_ticks, elapsed_ticks, handle, output ready);
endinterface

interface dltq_rsp_if;
   logic        valid;
   logic        ready;
   logic        event_valid;
   logic        event_kind;
   logic [15:0] event_handle;
   logic [15:0] assigned_id;
   logic        resched;
   logic [1:0]  status;
   logic        last;
   modport source (output valid, event_valid, event_kind, event_handle, assigned_id,
                   resched, status, last, input ready);
   modport sink (input valid, event_valid, event_kind, event_handle, assigned_id,
                 resched, status, last, output ready);
endinterface

[src/dltq_mem.sv]
module dltq_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[src/dltq_ctrl.sv]
module dltq_ctrl #(
   parameter int QUEUE_DEPTH = dltq_pkg::QUEUE_DEPTH_DEF,
   parameter int DELAY_WIDTH = dltq_pkg::DELAY_WIDTH_DEF,
   parameter int ID_WIDTH    = dltq_pkg::ID_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dltq_req_if.sink   req,
   dltq_rsp_if.source rsp
);
   import dltq_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int HW = 16;
   localparam int EW = DELAY_WIDTH + 1 + HW + 1 + AW;
   localparam int RW = $clog2(MAX_RESULTS + 1);

   // entry word: {delta, kind, handle, cancelled, next}
   logic          we;
   logic [AW-1:0] wa, ra;
   logic [EW-1:0] wd, rd;

   dltq_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_mem (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd), .rd_addr(ra), .rd_data(rd)
   );

   logic [DELAY_WIDTH-1:0] rd_delta;
   logic                   rd_kind, rd_canc;
   logic [HW-1:0]          rd_hnd;
   logic [AW-1:0]          rd_next;
   assign {rd_delta, rd_kind, rd_hnd, rd_canc, rd_next} = rd;

   state_type              state_ff, state_in;
   logic [AW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [QUEUE_DEPTH-1:0] free_ff, free_in;
   logic [ID_WIDTH-1:0]    nid_ff, nid_in;
   logic [DELAY_WIDTH-1:0] t_ff, t_in;
   logic [HW-1:0]          hnd_ff, hnd_in;
   logic                   kind_ff, kind_in;
   logic [AW-1:0]          cur_ff, cur_in, prev_ff, prev_in, slot_ff, slot_in;
   logic                   hasp_ff, hasp_in;
   logic [CW-1:0]          i_ff, i_in;
   logic [RW-1:0]          n_ff, n_in;
   logic                   any_ff, any_in;
   logic [AW-1:0]          pnext_ff, pnext_in;
   logic                   pkind_ff, pkind_in, pcanc_ff, pcanc_in;
   logic [DELAY_WIDTH-1:0] pdelta_ff, pdelta_in;
   logic [HW-1:0]          phnd_ff, phnd_in;
   logic                   ov_ff, ov_in;
   rsp_type                o_ff, o_in;
   logic                   pv_ff, pv_in;
   rsp_type                hold_ff, hold_in;
   logic                   o_free;
   logic                   emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         free_ff  <= '1;
         nid_ff   <= ID_WIDTH'(1);
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         free_ff  <= free_in;
         nid_ff   <= nid_in;
         ov_ff    <= ov_in;
      end
      t_ff <= t_in; hnd_ff <= hnd_in; kind_ff <= kind_in;
      cur_ff <= cur_in; prev_ff <= prev_in; slot_ff <= slot_in; hasp_ff <= hasp_in;
      i_ff <= i_in; n_ff <= n_in; any_ff <= any_in; o_ff <= o_in;
      pv_ff <= pv_in; hold_ff <= hold_in;
      pnext_ff <= pnext_in; pkind_ff <= pkind_in; pcanc_ff <= pcanc_in;
      pdelta_ff <= pdelta_in; phnd_ff <= phnd_in;
   end

   // first free slot
   logic [AW-1:0] fslot;
   always_comb begin
      fslot = '0;
      for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
         if (free_ff[k]) fslot = AW'(k);
      end
   end

   function automatic rsp_type mk(logic v, logic k, logic [HW-1:0] h,
                                  logic [HW-1:0] id, logic rs, status_type st,
                                  logic l);
      rsp_type r;
      r.event_valid  = v;
      r.event_kind   = k;
      r.event_handle = h;
      r.assigned_id  = id;
      r.resched      = rs;
      r.status       = st;
      r.last         = l;
      return r;
   endfunction

   assign req.ready = (state_ff == S_IDLE);
   assign o_free    = !ov_ff || rsp.ready;
   assign emit      = !(rd_kind && rd_canc);

   always_comb begin
      state_in = state_ff; head_in = head_ff; count_in = count_ff; free_in = free_ff;
      nid_in = nid_ff; t_in = t_ff; hnd_in = hnd_ff; kind_in = kind_ff;
      cur_in = cur_ff; prev_in = prev_ff; slot_in = slot_ff; hasp_in = hasp_ff;
      i_in = i_ff; n_in = n_ff; any_in = any_ff; o_in = o_ff;
      pv_in = pv_ff; hold_in = hold_ff;
      pnext_in = pnext_ff; pkind_in = pkind_ff; pcanc_in = pcanc_ff;
      pdelta_in = pdelta_ff; phnd_in = phnd_ff;
      we = 1'b0; wa = cur_ff; wd = rd; ra = cur_ff;

      // drop the result register once taken
      ov_in = ov_ff && !rsp.ready;

      case (state_ff)
         S_IDLE: begin
            ra = head_ff;
            if (req.valid) begin
               t_in    = DELAY_WIDTH'(req.delay_ticks);
               hnd_in  = req.handle;
               cur_in  = head_ff;
               slot_in = fslot;
               i_in    = '0;
               n_in    = '0;
               any_in  = 1'b0;
               hasp_in = 1'b0;
               pv_in   = 1'b0;
               hold_in = mk(1'b0, 1'b0, '0, '0, 1'b0, ST_OK, 1'b1);
               case (opcode_type'(req.opcode))
                  OP_TICK: begin
                     t_in = DELAY_WIDTH'(req.elapsed_ticks);
                     state_in = (count_ff != '0) ? S_TICK_CMP : S_TICK_END;
                  end
                  OP_SLEEP: begin
                     kind_in = 1'b0;
                     if (count_ff >= CW'(QUEUE_DEPTH)) begin
                        hold_in.status = ST_FULL;
                        state_in = S_OUT;
                     end else begin
                        state_in = (count_ff != '0) ? S_INS_CMP : S_INS_LINK;
                     end
                  end
                  OP_SCHED: begin
                     kind_in = 1'b1;
                     if (count_ff >= CW'(QUEUE_DEPTH)) begin
                        hold_in.status = ST_FULL;
                        state_in = S_OUT;
                     end else if (nid_ff == '0) begin
                        hold_in.status = ST_NO_IDS;
                        state_in = S_OUT;
                     end else begin
                        hnd_in = HW'(nid_ff);
                        hold_in.assigned_id = HW'(nid_ff);
                        nid_in = nid_ff + ID_WIDTH'(1);
                        state_in = (count_ff != '0) ? S_INS_CMP : S_INS_LINK;
                     end
                  end
                  OP_CANCEL: begin
                     if (count_ff != '0) begin
                        state_in = S_CAN_CMP;
                     end else begin
                        hold_in.status = ST_NOT_FOUND;
                        state_in = S_OUT;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INS_CMP: begin
            if (t_ff < rd_delta) begin
               we = 1'b1;
               wd = {rd_delta - t_ff, rd_kind, rd_hnd, rd_canc, rd_next};
               state_in = S_INS_LINK;
            end else begin
               t_in = t_ff - rd_delta;
               prev_in = cur_ff; hasp_in = 1'b1;
               pnext_in = rd_next; pkind_in = rd_kind; pcanc_in = rd_canc;
               pdelta_in = rd_delta; phnd_in = rd_hnd;
               cur_in = rd_next;
               ra = rd_next;
               i_in = i_ff + CW'(1);
               state_in = (i_ff + CW'(1) < count_ff) ? S_INS_CMP : S_INS_LINK;
            end
         end
         S_INS_LINK: begin
            we = 1'b1; wa = slot_ff;
            wd = {t_ff, kind_ff, hnd_ff, 1'b0, hasp_ff ? pnext_ff : head_ff};
            free_in[slot_ff] = 1'b0;
            count_in = count_ff + CW'(1);
            if (hasp_ff) begin
               state_in = S_INS_PATCH;
            end else begin
               head_in = slot_ff;
               state_in = S_OUT;
            end
         end
         S_INS_PATCH: begin
            // patch predecessor link
            we = 1'b1; wa = prev_ff;
            wd = {pdelta_ff, pkind_ff, phnd_ff, pcanc_ff, slot_ff};
            state_in = S_OUT;
         end
         S_CAN_CMP: begin
            if (rd_kind && rd_hnd == hnd_ff) begin
               we = 1'b1;
               wd = {rd_delta, rd_kind, rd_hnd, 1'b1, rd_next};
               state_in = S_OUT;
            end else if (i_ff + CW'(1) >= count_ff) begin
               hold_in.status = ST_NOT_FOUND;
               state_in = S_OUT;
            end else begin
               cur_in = rd_next;
               ra = rd_next;
               i_in = i_ff + CW'(1);
            end
         end
         S_TICK_CMP: begin
            if (rd_delta > t_ff) begin
               we = 1'b1;
               wd = {rd_delta - t_ff, rd_kind, rd_hnd, rd_canc, rd_next};
               state_in = S_TICK_END;
            end else if (!(emit && pv_ff) || o_free) begin
               t_in = t_ff - rd_delta;
               any_in = 1'b1;
               head_in = rd_next; cur_in = rd_next;
               ra = rd_next;
               free_in[cur_ff] = 1'b1;
               count_in = count_ff - CW'(1);
               if (emit) begin
                  // hand out the held event, hold the new one
                  if (pv_ff) begin
                     o_in = hold_ff;
                     ov_in = 1'b1;
                  end
                  hold_in = mk(1'b1, rd_kind, rd_hnd, '0, 1'b1, ST_OK, 1'b0);
                  pv_in = 1'b1;
                  n_in = n_ff + RW'(1);
               end
               if (count_ff == CW'(1)) begin
                  state_in = S_TICK_END;
               end else if (emit && n_ff + RW'(1) == RW'(MAX_RESULTS)) begin
                  state_in = S_TICK_REST;
               end
            end
         end
         S_TICK_REST: begin
            // saturating subtract of leftover ticks from the new head
            if (t_ff != '0) begin
               we = 1'b1;
               wd = {(rd_delta > t_ff) ? (rd_delta - t_ff) : {DELAY_WIDTH{1'b0}},
                     rd_kind, rd_hnd, rd_canc, rd_next};
            end
            state_in = S_TICK_END;
         end
         S_TICK_END: begin
            if (pv_ff) hold_in.last = 1'b1;
            else hold_in = mk(1'b0, 1'b0, '0, '0, any_ff, ST_OK, 1'b1);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (o_free) begin
               o_in = hold_ff;
               ov_in = 1'b1;
               pv_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp.valid        = ov_ff;
   assign rsp.event_valid  = o_ff.event_valid;
   assign rsp.event_kind   = o_ff.event_kind;
   assign rsp.event_handle = o_ff.event_handle;
   assign rsp.assigned_id  = o_ff.assigned_id;
   assign rsp.resched      = o_ff.resched;
   assign rsp.status       = o_ff.status;
   assign rsp.last         = o_ff.last;
endmodule

[src/delta_list_timer_queue.sv]
// Timer queue kept as a delta list in one entry memory.
// Channels: req (opcode, delay_ticks, elapsed_ticks, handle) and rsp
// (event_valid, event_kind, event_handle, assigned_id, resched, status,
// last); each transfer needs valid and ready high at a clock edge.
// Insert and cancel give one result, a tick one or more, the last with last set.
// Steps: an insert compares one entry per cycle, then links and patches;
// a cancel walks the list until a scheduled handle matches; a tick removes
// each expired entry, then lowers the delta of the first entry that stays,
// or of the new head when the result limit stops it, and then closes.
// Rate is set by the single read port of the entry memory; one item is
// worked on at a time and the next is taken the cycle after its last
// result is loaded.
// Reset empties the list, frees every slot and sets the id counter to one;
// the entry memory needs no clearing pass.
// When the receiver stalls, the result register holds; a tick walk waits
// for the register before it hands out each event, and a new request is
// taken while the last result of the previous one still waits.
module delta_list_timer_queue #(
   parameter int QUEUE_DEPTH = dltq_pkg::QUEUE_DEPTH_DEF,
   parameter int DELAY_WIDTH = dltq_pkg::DELAY_WIDTH_DEF,
   parameter int ID_WIDTH    = dltq_pkg::ID_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dltq_req_if.sink   req,
   dltq_rsp_if.source rsp
);
   import dltq_pkg::*;

   // hold all list control and the entry memory in one walker
   dltq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH), .DELAY_WIDTH(DELAY_WIDTH),
               .ID_WIDTH(ID_WIDTH)) u_ctrl (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp)
   );
endmodule

[src/dltq_checker.sv]
`include "delta_list_timer_queue_defines.svh"
module dltq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_event_valid,
   input logic [15:0] rsp_event_handle,
   input logic [1:0]  rsp_status,
   input logic        rsp_resched
);
   import dltq_pkg::*;

   `DLTQ_ASSERT_IMPL(a_evt_resched, clock, reset, rsp_valid && rsp_event_valid, rsp_resched, "event without resched")
   `DLTQ_ASSERT_IMPL(a_evt_status, clock, reset, rsp_valid && rsp_event_valid, rsp_status == ST_OK, "event with status")
   `DLTQ_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "ready after accept")
   `DLTQ_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_handle), "stalled result changed")
endmodule

bind delta_list_timer_queue dltq_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_event_valid(rsp.event_valid),
   .rsp_event_handle(rsp.event_handle), .rsp_status(rsp.status),
   .rsp_resched(rsp.resched)
);
